// ===== rtl/ptm_pkg.sv =====
// Shared types and constants for the page table mapper.
`default_nettype none
package ptm_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned PN_W          = 20;   // page number width
  localparam int unsigned FLAGS_W       = 12;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned DIR_W         = 10;

  localparam logic [DIR_W-1:0] DIR_LOW  = 10'h000;
  localparam logic [DIR_W-1:0] DIR_HIGH = 10'h300;

  localparam logic [OP_W-1:0] OP_MAP_ONE   = 2'd0;
  localparam logic [OP_W-1:0] OP_MAP_RANGE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ      = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALIGN    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REGION   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd4;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LEN_P = 7'b0000100,
    S_LEN_V = 7'b0001000,
    S_RD    = 7'b0010000,
    S_CHK   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // table write strobes
  typedef struct packed {
    logic we_lo;
    logic we_hi;
  } tbl_req_t;

endpackage
`default_nettype wire

// ===== rtl/ptm_sub.sv =====
// Shared 32-bit subtractor for the range length computations.
`default_nettype none
module ptm_sub (
  input  wire logic [ptm_pkg::ADDR_W-1:0] a,
  input  wire logic [ptm_pkg::ADDR_W-1:0] b,
  output logic      [ptm_pkg::ADDR_W-1:0] diff
);
  import ptm_pkg::*;

  assign diff = a - b;

endmodule
`default_nettype wire

// ===== rtl/ptm_tables.sv =====
// Low and high region page tables, one shared address, registered reads.
`default_nettype none
module ptm_tables #(
  parameter int unsigned ENTRIES = ptm_pkg::TABLE_ENTRIES,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  wire logic                         clk,
  input  wire ptm_pkg::tbl_req_t            req,
  input  wire logic [AW-1:0]                addr,
  input  wire logic [ptm_pkg::ADDR_W-1:0]   wdata,
  output logic      [ptm_pkg::ADDR_W-1:0]   rdata_lo,
  output logic      [ptm_pkg::ADDR_W-1:0]   rdata_hi
);
  import ptm_pkg::*;

  logic [ADDR_W-1:0] low_mem  [ENTRIES];
  logic [ADDR_W-1:0] high_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we_lo) begin
      low_mem[addr] <= wdata;
    end
    rdata_lo <= low_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (req.we_hi) begin
      high_mem[addr] <= wdata;
    end
    rdata_hi <= high_mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/ptm_ctrl.sv =====
// Request sequencer: checks, range walk, table access and result register.
`default_nettype none
module ptm_ctrl #(
  parameter int unsigned ENTRIES = ptm_pkg::TABLE_ENTRIES,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ptm_pkg::OP_W-1:0]       op,
  input  wire logic [ptm_pkg::ADDR_W-1:0]     pa_base,
  input  wire logic [ptm_pkg::ADDR_W-1:0]     pa_limit,
  input  wire logic [ptm_pkg::ADDR_W-1:0]     va_base,
  input  wire logic [ptm_pkg::ADDR_W-1:0]     va_limit,
  input  wire logic [ptm_pkg::FLAGS_W-1:0]    flags,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [ptm_pkg::STATUS_W-1:0]   status,
  output logic      [ptm_pkg::ADDR_W-1:0]     entry_word,
  output ptm_pkg::tbl_req_t                   tbl_req,
  output logic      [AW-1:0]                  tbl_addr,
  output logic      [ptm_pkg::ADDR_W-1:0]     tbl_wdata,
  input  wire logic [ptm_pkg::ADDR_W-1:0]     tbl_rdata_lo,
  input  wire logic [ptm_pkg::ADDR_W-1:0]     tbl_rdata_hi
);
  import ptm_pkg::*;

  state_t state, state_next;

  logic [OP_W-1:0]     op_r;
  logic [ADDR_W-1:0]   ps, pe, vs, ve;
  logic [FLAGS_W-1:0]  flags_r;
  logic [ADDR_W-1:0]   len_p;
  logic [PN_W-1:0]     vpn, ppn, count;
  logic                hi_sel;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_word;
  logic [AW-1:0]       clr_idx;

  logic [ADDR_W-1:0]   sub_a, sub_b, sub_diff;
  logic [DIR_W-1:0]    dir;
  logic [ADDR_W-1:0]   rd_word;
  logic                in_fire;
  logic                out_load;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);
  assign dir      = vpn[PN_W-1 -: DIR_W];
  assign rd_word  = hi_sel ? tbl_rdata_hi : tbl_rdata_lo;

  // one subtractor serves both range lengths
  assign sub_a = (state == S_LEN_P) ? pe : ve;
  assign sub_b = (state == S_LEN_P) ? ps : vs;

  ptm_sub u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff)
  );

  always_comb begin
    tbl_req   = '0;
    tbl_addr  = vpn[AW-1:0];
    tbl_wdata = {ppn, flags_r[FLAGS_W-1:1], 1'b1};
    if (state == S_CLEAR) begin
      tbl_req.we_lo = 1'b1;
      tbl_req.we_hi = 1'b1;
      tbl_addr      = clr_idx;
      tbl_wdata     = '0;
    end else if (state == S_CHK && op_r != OP_READ && !rd_word[0]) begin
      tbl_req.we_lo = !hi_sel;
      tbl_req.we_hi = hi_sel;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == AW'(ENTRIES - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          case (op)
            OP_MAP_ONE: begin
              if ((pa_base[11:0] | va_base[11:0]) != '0) state_next = S_OUT;
              else state_next = S_RD;
            end
            OP_MAP_RANGE: begin
              if ((pa_base[11:0] | pa_limit[11:0] | va_base[11:0]
                   | va_limit[11:0]) != '0) state_next = S_OUT;
              else state_next = S_LEN_P;
            end
            OP_READ: state_next = S_RD;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_LEN_P: state_next = S_LEN_V;
      S_LEN_V: begin
        if (sub_diff != len_p || len_p[ADDR_W-1:12] == '0) state_next = S_OUT;
        else state_next = S_RD;
      end
      S_RD: begin
        if (dir != DIR_LOW && dir != DIR_HIGH) state_next = S_OUT;
        else state_next = S_CHK;
      end
      S_CHK: begin
        if (op_r == OP_READ || rd_word[0] || count == PN_W'(1)) state_next = S_OUT;
        else state_next = S_RD;
      end
      S_OUT: if (out_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          op_r       <= op;
          ps         <= pa_base;
          pe         <= pa_limit;
          vs         <= va_base;
          ve         <= va_limit;
          flags_r    <= flags;
          vpn        <= va_base[ADDR_W-1:12];
          ppn        <= pa_base[ADDR_W-1:12];
          count      <= PN_W'(1);
          res_word   <= '0;
          if ((op == OP_MAP_ONE && (pa_base[11:0] | va_base[11:0]) != '0)
              || (op == OP_MAP_RANGE && (pa_base[11:0] | pa_limit[11:0]
              | va_base[11:0] | va_limit[11:0]) != '0)) begin
            res_status <= ST_ALIGN;
          end else begin
            res_status <= ST_OK;
          end
        end
      end
      S_LEN_P: len_p <= sub_diff;
      S_LEN_V: begin
        count <= len_p[ADDR_W-1:12];
        if (sub_diff != len_p) res_status <= ST_MISMATCH;
      end
      S_RD: begin
        hi_sel <= (dir == DIR_HIGH);
        if (dir != DIR_LOW && dir != DIR_HIGH) res_status <= ST_REGION;
      end
      S_CHK: begin
        if (op_r == OP_READ) begin
          res_word <= rd_word;
        end else if (rd_word[0]) begin
          res_status <= ST_PRESENT;
        end else begin
          count <= count - PN_W'(1);
          vpn   <= vpn + PN_W'(1);
          ppn   <= ppn + PN_W'(1);
        end
      end
      S_OUT: begin
        if (out_load) begin
          status     <= res_status;
          entry_word <= res_word;
        end
      end
      default: ;
    endcase
  end

  a_both_tables_only_clear: assert property (@(posedge clk) disable iff (rst)
    (tbl_req.we_lo && tbl_req.we_hi) |-> state == S_CLEAR)
    else $error("both tables written outside the clearing pass");

  a_write_then_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK && (tbl_req.we_lo || tbl_req.we_hi)) |=> (state == S_RD || state == S_OUT))
    else $error("page write not followed by next page or result");

  a_walk_has_pages: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD && op_r != OP_READ) |-> count != '0)
    else $error("page walk with no pages left");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result appeared without passing the result state");

endmodule
`default_nettype wire

// ===== rtl/page_table_mapper.sv =====
// Page table mapper top level: stream ports, sequencer and the two tables.
//
//  channel | direction | tdata / tuser contents
//  s_*     | in        | tuser: op; tdata: pa_base, pa_limit, va_base, va_limit, flags
//  m_*     | out       | tdata: status, entry_word
//
// Single map and read: table read, check and write, result register, then back to idle;
// a new request is accepted only in idle.
// Range map: the two lengths on the shared subtractor, then per page a table read and
// a check and write, then the result register; unaligned requests go straight to it.
// After reset a clearing pass zeroes all 1024 entries of both tables; s_tready is low during it.
// A result waits in the output register while the next item is accepted.
`default_nettype none
module page_table_mapper #(
  parameter int unsigned TABLE_ENTRIES = ptm_pkg::TABLE_ENTRIES
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [143:0] s_tdata,  // pa_base, pa_limit, va_base, va_limit, flags, pad
  input  wire logic [1:0]   s_tuser,  // op
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [39:0]  m_tdata   // status, entry_word, pad
);
  import ptm_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  tbl_req_t             tbl_req;
  logic [AW-1:0]        tbl_addr;
  logic [ADDR_W-1:0]    tbl_wdata, tbl_rdata_lo, tbl_rdata_hi;
  logic [STATUS_W-1:0]  status;
  logic [ADDR_W-1:0]    entry_word;

  ptm_ctrl #(
    .ENTRIES (TABLE_ENTRIES),
    .AW      (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .op           (s_tuser),
    .pa_base      (s_tdata[31:0]),
    .pa_limit     (s_tdata[63:32]),
    .va_base      (s_tdata[95:64]),
    .va_limit     (s_tdata[127:96]),
    .flags        (s_tdata[139:128]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (status),
    .entry_word   (entry_word),
    .tbl_req      (tbl_req),
    .tbl_addr     (tbl_addr),
    .tbl_wdata    (tbl_wdata),
    .tbl_rdata_lo (tbl_rdata_lo),
    .tbl_rdata_hi (tbl_rdata_hi)
  );

  ptm_tables #(
    .ENTRIES (TABLE_ENTRIES),
    .AW      (AW)
  ) u_tables (
    .clk      (clk),
    .req      (tbl_req),
    .addr     (tbl_addr),
    .wdata    (tbl_wdata),
    .rdata_lo (tbl_rdata_lo),
    .rdata_hi (tbl_rdata_hi)
  );

  assign m_tdata = {5'b0, entry_word, status};

endmodule
`default_nettype wire

// ===== tb/ptm_checker.sv =====
// Checker for the page table mapper: mirrors both tables, predicts each response and compares.
`timescale 1ns / 100ps
module ptm_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,   // pa_base, pa_limit, va_base, va_limit, flags, pad
  input  logic [1:0]   s_tuser,   // op
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [39:0]  m_tdata,   // status, entry_word, pad
  output int           errors,
  output int           outstanding,
  output int           requests,
  output int           responses,
  output logic [4:0]   status_seen
);
  import ptm_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [31:0]         word;
  } ptm_resp_t;

  ptm_resp_t   resp_fifo[$];
  logic [31:0] low_tbl  [TABLE_ENTRIES];
  logic [31:0] high_tbl [TABLE_ENTRIES];

  int         fail_cnt   = 0;
  int         wait_cnt   = 0;
  int         req_cnt    = 0;
  int         resp_cnt   = 0;
  logic [4:0] codes_seen = '0;

  assign errors      = fail_cnt;
  assign outstanding = wait_cnt;
  assign requests    = req_cnt;
  assign responses   = resp_cnt;
  assign status_seen = codes_seen;

  // 0 low table, 1 high table, -1 outside both
  function automatic int bank_of(input logic [31:0] va);
    if (va[31:22] == DIR_LOW)  return 0;
    if (va[31:22] == DIR_HIGH) return 1;
    return -1;
  endfunction

  function automatic logic [STATUS_W-1:0] map_page(input logic [31:0] pa, input logic [31:0] va,
                                                    input logic [11:0] fl);
    logic [9:0]  idx;
    logic [31:0] cur;
    int          bank;
    idx = va[21:12];
    if (pa[11:0] != 12'h000 || va[11:0] != 12'h000) return ST_ALIGN;
    bank = bank_of(va);
    if (bank < 0) return ST_REGION;
    cur = (bank == 1) ? high_tbl[idx] : low_tbl[idx];
    if (cur[0]) return ST_PRESENT;
    if (bank == 1) high_tbl[idx] = {pa[31:12], fl[11:1], 1'b1};
    else           low_tbl[idx]  = {pa[31:12], fl[11:1], 1'b1};
    return ST_OK;
  endfunction

  // page walk stops at the first failing page; earlier pages stay mapped
  function automatic logic [STATUS_W-1:0] map_span(input logic [31:0] ps, input logic [31:0] pe,
                                                    input logic [31:0] vs, input logic [31:0] ve,
                                                    input logic [11:0] fl);
    logic [31:0]         len;
    logic [31:0]         off;
    logic [STATUS_W-1:0] st;
    int unsigned         i;
    int unsigned         npages;
    if (((ps | pe | vs | ve) & 32'h0000_0fff) != 32'h0) return ST_ALIGN;
    len = pe - ps;
    if (len != ve - vs) return ST_MISMATCH;
    npages = len[31:12];
    st = ST_OK;
    off = 32'h0;
    for (i = 0; i < npages && st == ST_OK; i++) begin
      st = map_page(ps + off, vs + off, fl);
      off = off + 32'd4096;
    end
    return st;
  endfunction

  function automatic ptm_resp_t predict_resp(input logic [1:0] op, input logic [143:0] d);
    ptm_resp_t r;
    int        bank;
    r.status = ST_OK;
    r.word   = 32'h0;
    case (op)
      OP_MAP_ONE:   r.status = map_page(d[31:0], d[95:64], d[139:128]);
      OP_MAP_RANGE: r.status = map_span(d[31:0], d[63:32], d[95:64], d[127:96], d[139:128]);
      OP_READ: begin
        bank = bank_of(d[95:64]);
        if (bank < 0)       r.status = ST_REGION;
        else if (bank == 1) r.word = high_tbl[d[85:76]];
        else                r.word = low_tbl[d[85:76]];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    ptm_resp_t exp_r;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        low_tbl[i]  = 32'h0;
        high_tbl[i] = 32'h0;
      end
      resp_fifo.delete();
      wait_cnt = 0;
    end else begin
      // retire the response first: it belongs to an older request
      if (m_tvalid && m_tready) begin
        resp_cnt++;
        if (resp_fifo.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected item, expected none, got status %0d word %h",
                   $time, m_tdata[2:0], m_tdata[34:3]);
        end else begin
          exp_r = resp_fifo.pop_front();
          if (m_tdata[2:0] < 5) codes_seen[m_tdata[2:0]] = 1'b1;
          if (m_tdata[2:0] !== exp_r.status) begin
            fail_cnt++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, exp_r.status, m_tdata[2:0]);
          end
          if (m_tdata[34:3] !== exp_r.word) begin
            fail_cnt++;
            $display("%0t: entry_word mismatch, expected %h, got %h",
                     $time, exp_r.word, m_tdata[34:3]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req_cnt++;
        resp_fifo.push_back(predict_resp(s_tuser, s_tdata));
      end
      wait_cnt = resp_fifo.size();
    end
  end

endmodule

// ===== tb/tb_page_table_mapper.sv =====
// Testbench top for the page table mapper: clock, reset, request and response traffic, verdict.
`timescale 1ns / 100ps
module tb_page_table_mapper;
  import ptm_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;   // unused op, must be a no-op
  localparam int NUM_RANDOM      = 400;
  // covers the clearing pass and a full-table range walk
  localparam int WATCHDOG_LIMIT  = 8000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;

  int         errors;
  int         outstanding;
  int         requests;
  int         responses;
  logic [4:0] status_seen;
  int         quiet_cycles = 0;
  bit         no_gaps = 1'b0;

  always #5 clk = ~clk;

  page_table_mapper dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ptm_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding),
    .requests    (requests),
    .responses   (responses),
    .status_seen (status_seen)
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // response side: random stall before each item
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      m_tready = 1'b0;
      repeat (stall) @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_req(input logic [1:0] op, input logic [31:0] ps, input logic [31:0] pe,
                          input logic [31:0] vs, input logic [31:0] ve, input logic [11:0] fl);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {4'h0, fl, ve, vs, pe, ps};
    s_tuser  = op;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // virtual page biased to a small set of slots so collisions happen
  function automatic logic [31:0] pick_vpage();
    logic [9:0] dir;
    logic [9:0] idx;
    int         r;
    r = $urandom_range(0, 99);
    dir = (r < 45) ? DIR_LOW : (r < 90) ? DIR_HIGH : 10'($urandom);
    idx = ($urandom_range(0, 99) < 60) ? 10'($urandom_range(0, 47)) : 10'($urandom);
    return {dir, idx, 12'h000};
  endfunction

  function automatic logic [31:0] pick_ppage();
    return {20'($urandom), 12'h000};
  endfunction

  initial begin
    logic [31:0] ps, pe, vs, ve;
    logic [11:0] fl;
    logic [31:0] span;
    int          kind;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, every op, every status
    send_req(OP_READ,      32'h0,         32'h0,         32'h0000_0000, 32'h0,         12'h000);
    send_req(OP_MAP_ONE,   32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    send_req(OP_READ,      32'h0,         32'h0,         32'h0000_0FFF, 32'h0,         12'h000);
    send_req(OP_MAP_ONE,   32'h0000_2000, 32'h0,         32'h0000_0000, 32'h0,         12'h123);
    send_req(OP_MAP_ONE,   32'h0000_1001, 32'h0,         32'h0000_5000, 32'h0,         12'h0F0);
    send_req(OP_MAP_ONE,   32'h0000_1000, 32'h0,         32'h0000_1800, 32'h0,         12'h0F0);
    send_req(OP_MAP_ONE,   32'h0000_1000, 32'h0,         32'h0040_0000, 32'h0,         12'h0F0);
    send_req(OP_MAP_ONE,   32'h0000_1000, 32'h0,         32'hFFFF_F000, 32'h0,         12'h0F0);
    send_req(OP_MAP_ONE,   32'h0000_0000, 32'h0,         32'hC000_0000, 32'h0,         12'h000);
    send_req(OP_MAP_ONE,   32'h1234_5000, 32'h0,         32'hC03F_F000, 32'h0,         12'hAAA);
    send_req(OP_READ,      32'h0,         32'h0,         32'hC03F_F123, 32'h0,         12'h000);
    send_req(OP_READ,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 12'hFFF);
    send_req(OP_NONE,      32'hDEAD_BEEF, 32'h1234_5678, 32'h0000_3000, 32'hFFFF_FFFF, 12'hFFF);
    // empty range
    send_req(OP_MAP_RANGE, 32'h0000_5000, 32'h0000_5000, 32'h0000_2000, 32'h0000_2000, 12'h007);
    // length mismatch
    send_req(OP_MAP_RANGE, 32'h0001_0000, 32'h0001_3000, 32'h0001_0000, 32'h0001_2000, 12'h007);
    // unaligned end
    send_req(OP_MAP_RANGE, 32'h0001_0000, 32'h0001_3004, 32'h0001_0000, 32'h0001_3004, 12'h007);
    // physical pages wrap past the top of the address space
    send_req(OP_MAP_RANGE, 32'hFFFF_E000, 32'h0000_2000, 32'h0001_0000, 32'h0001_4000, 12'h555);
    // runs into a page mapped just before: first two pages stick
    send_req(OP_MAP_RANGE, 32'h0070_0000, 32'h0070_4000, 32'h0000_E000, 32'h0001_2000, 12'h003);
    send_req(OP_READ,      32'h0,         32'h0,         32'h0000_F000, 32'h0,         12'h000);
    // reversed range: huge wrapped length, stops on the page mapped at index 1023
    send_req(OP_MAP_RANGE, 32'h0000_2000, 32'h0000_1000, 32'hC03F_D000, 32'hC03F_C000, 12'h00F);
    // walks off the end of the low table into an invalid directory
    send_req(OP_MAP_RANGE, 32'h0010_0000, 32'h0010_3000, 32'h003F_E000, 32'h0040_1000, 12'h801);
    send_req(OP_READ,      32'h0,         32'h0,         32'h003F_F000, 32'h0,         12'h000);

    drain();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) drain();
      no_gaps = (n >= 100 && n < 140);
      kind = $urandom_range(0, 99);
      ps = pick_ppage();
      vs = pick_vpage();
      pe = $urandom;
      ve = $urandom;
      fl = 12'($urandom);
      if (kind < 40) begin
        if ($urandom_range(0, 99) < 15) begin
          if ($urandom_range(0, 1) != 0) ps[11:0] = 12'($urandom_range(1, 4095));
          else                           vs[11:0] = 12'($urandom_range(1, 4095));
        end
        send_req(OP_MAP_ONE, ps, pe, vs, ve, fl);
      end else if (kind < 70) begin
        span = ($urandom_range(0, 99) < 5) ? 32'($urandom_range(8, 40)) << 12
                                           : 32'($urandom_range(0, 6)) << 12;
        if ($urandom_range(0, 99) < 4) span = 32'h0 - (32'($urandom_range(1, 8)) << 12);
        pe = ps + span;
        ve = vs + span;
        if ($urandom_range(0, 99) < 10) ve = ve + (32'($urandom_range(1, 3)) << 12);
        if ($urandom_range(0, 99) < 8) begin
          case ($urandom_range(0, 3))
            0:       ps[11:0] = 12'($urandom_range(1, 4095));
            1:       pe[11:0] = 12'($urandom_range(1, 4095));
            2:       vs[11:0] = 12'($urandom_range(1, 4095));
            default: ve[11:0] = 12'($urandom_range(1, 4095));
          endcase
        end
        send_req(OP_MAP_RANGE, ps, pe, vs, ve, fl);
      end else if (kind < 93) begin
        vs[11:0] = 12'($urandom);
        send_req(OP_READ, ps, pe, vs, ve, fl);
      end else begin
        send_req(OP_NONE, $urandom, pe, $urandom, ve, fl);
      end
    end

    s_tvalid = 1'b0;
    no_gaps = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Run sent %0d requests (directed and random single maps, ranges, reads, no-ops)",
             requests);
    $display("and checked %0d responses; status codes returned, bit per code 4..0: %b",
             responses, status_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
